// File: hdl/tpd_pkg.sv
// Package for the terminal prompt detector: beat types, config register
// indexes, verdict codes and the two fixed notice texts. No dependencies.
package tpd_pkg;

   localparam int PROMPT_MAX_BYTES   = 32;
   localparam int PROMPT_BYTE_COUNT  = 32;
   localparam int PROMPT_IDX_W       = $clog2(PROMPT_BYTE_COUNT);
   localparam int PROMPT_LEN_W       = 6;
   localparam int CSR_INDEX_W        = 3;
   localparam int CSR_DATA_W         = 64;
   localparam int CSR_BYTE_REGS      = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_PROMPT_LENGTH   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PROMPT_BYTES_0  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PROMPT_BYTES_8  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PROMPT_BYTES_16 = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PROMPT_BYTES_24 = 3'd4;

   localparam logic [PROMPT_LEN_W-1:0] PROMPT_LENGTH_RESET = 6'd7;
   localparam logic [CSR_DATA_W-1:0]   PROMPT_BYTES_0_RESET = 64'h0064_726F_7773_7361;

   localparam logic [1:0] VERDICT_NONE      = 2'd0;
   localparam logic [1:0] VERDICT_WRONG_PW  = 2'd1;
   localparam logic [1:0] VERDICT_HOST_NEW  = 2'd2;
   localparam logic [1:0] VERDICT_KEY_DIFF  = 2'd3;

   localparam int HOST_LEN   = 25;
   localparam int HOST_POS_W = 5;
   localparam int KEY_LEN    = 39;
   localparam int KEY_POS_W  = 6;

   localparam logic [HOST_LEN*8-1:0] HOST_TEXT = "The authenticity of host ";
   localparam logic [KEY_LEN*8-1:0]  KEY_TEXT  =
      "differs from the key for the IP address";

   typedef struct packed {
      logic [7:0] term_byte;
      logic       chunk_end;
   } tpd_req_type;

   typedef struct packed {
      logic       send_password;
      logic [1:0] verdict;
      logic       halted;
   } tpd_rsp_type;

   typedef struct packed {
      logic [PROMPT_LEN_W-1:0]                len_eff;
      logic [PROMPT_BYTE_COUNT-1:0][7:0]      bytes;
   } tpd_prompt_cfg_type;

   function automatic logic [7:0] host_byte(input logic [HOST_POS_W-1:0] pos);
      logic [7:0] b;
      b = 8'd0;
      if (int'(pos) < HOST_LEN) b = HOST_TEXT[8*(HOST_LEN-1-int'(pos)) +: 8];
      return b;
   endfunction

   function automatic logic [7:0] key_byte(input logic [KEY_POS_W-1:0] pos);
      logic [7:0] b;
      b = 8'd0;
      if (int'(pos) < KEY_LEN) b = KEY_TEXT[8*(KEY_LEN-1-int'(pos)) +: 8];
      return b;
   endfunction

endpackage

// File: hdl/tpd_csr.sv
// Prompt configuration registers: length and pattern bytes.
// Depends on tpd_pkg.
module tpd_csr
   import tpd_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_valid,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_data,
   output tpd_prompt_cfg_type       prompt_cfg
);

   logic [PROMPT_LEN_W-1:0]                    len_ff;
   logic [PROMPT_LEN_W-1:0]                    len_in;
   logic [CSR_BYTE_REGS-1:0][CSR_DATA_W-1:0]   bytes_ff;
   logic [CSR_BYTE_REGS-1:0][CSR_DATA_W-1:0]   bytes_in;

   always_comb begin
      len_in   = len_ff;
      bytes_in = bytes_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_PROMPT_LENGTH:   len_in      = csr_data[PROMPT_LEN_W-1:0];
            CSR_PROMPT_BYTES_0:  bytes_in[0] = csr_data;
            CSR_PROMPT_BYTES_8:  bytes_in[1] = csr_data;
            CSR_PROMPT_BYTES_16: bytes_in[2] = csr_data;
            CSR_PROMPT_BYTES_24: bytes_in[3] = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= PROMPT_LENGTH_RESET;
         bytes_ff <= {{(CSR_BYTE_REGS-1)*CSR_DATA_W{1'b0}}, PROMPT_BYTES_0_RESET};
      end else begin
         len_ff   <= len_in;
         bytes_ff <= bytes_in;
      end
   end

   always_comb begin
      if (len_ff > PROMPT_LEN_W'(PROMPT_MAX_BYTES)) begin
         prompt_cfg.len_eff = PROMPT_LEN_W'(PROMPT_MAX_BYTES);
      end else begin
         prompt_cfg.len_eff = len_ff;
      end
      prompt_cfg.bytes = bytes_ff;
   end

endmodule

// File: hdl/tpd_core.sv
// Matcher state and verdict logic: three position counters, prompt-seen
// and halt flags, updated once per advancing beat. Depends on tpd_pkg.
module tpd_core
   import tpd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  tpd_req_type          item,
   input  tpd_prompt_cfg_type   prompt_cfg,
   output tpd_rsp_type          result
);

   logic [PROMPT_LEN_W-1:0] prompt_pos_ff, prompt_pos_in, prompt_adv;
   logic [HOST_POS_W-1:0]   host_pos_ff, host_pos_in, host_adv;
   logic [KEY_POS_W-1:0]    key_pos_ff, key_pos_in, key_adv;
   logic                    seen_ff, seen_in;
   logic                    stopped_ff, stopped_in;
   logic [7:0]              prompt_cur;
   logic [7:0]              b;

   assign b = item.term_byte;
   assign prompt_cur = (prompt_pos_ff >= PROMPT_LEN_W'(PROMPT_BYTE_COUNT)) ? 8'd0 :
                       prompt_cfg.bytes[prompt_pos_ff[PROMPT_IDX_W-1:0]];

   always_comb begin
      priority if (prompt_pos_ff >= prompt_cfg.len_eff) begin
         prompt_adv = prompt_pos_ff;
      end else if (prompt_cur == b) begin
         prompt_adv = prompt_pos_ff + PROMPT_LEN_W'(1);
      end else begin
         prompt_adv = PROMPT_LEN_W'(prompt_cfg.bytes[0] == b);
      end
   end

   always_comb begin
      priority if (host_pos_ff >= HOST_POS_W'(HOST_LEN)) begin
         host_adv = host_pos_ff;
      end else if (host_byte(host_pos_ff) == b) begin
         host_adv = host_pos_ff + HOST_POS_W'(1);
      end else begin
         host_adv = HOST_POS_W'(host_byte('0) == b);
      end
   end

   always_comb begin
      priority if (key_pos_ff >= KEY_POS_W'(KEY_LEN)) begin
         key_adv = key_pos_ff;
      end else if (key_byte(key_pos_ff) == b) begin
         key_adv = key_pos_ff + KEY_POS_W'(1);
      end else begin
         key_adv = KEY_POS_W'(key_byte('0) == b);
      end
   end

   always_comb begin
      prompt_pos_in = prompt_pos_ff;
      host_pos_in   = host_pos_ff;
      key_pos_in    = key_pos_ff;
      seen_in       = seen_ff;
      stopped_in    = stopped_ff;
      result.send_password = 1'b0;
      result.verdict       = VERDICT_NONE;
      if (!stopped_ff) begin
         prompt_pos_in = prompt_adv;
         host_pos_in   = host_adv;
         key_pos_in    = key_adv;
         if (item.chunk_end) begin
            if (prompt_adv >= prompt_cfg.len_eff) begin
               if (!seen_ff) begin
                  result.send_password = 1'b1;
                  prompt_pos_in        = '0;
                  seen_in              = 1'b1;
               end else begin
                  result.verdict = VERDICT_WRONG_PW;
                  stopped_in     = 1'b1;
               end
            end
            if (!stopped_in) begin
               priority if (host_adv >= HOST_POS_W'(HOST_LEN)) begin
                  result.verdict = VERDICT_HOST_NEW;
                  stopped_in     = 1'b1;
               end else if (key_adv >= KEY_POS_W'(KEY_LEN)) begin
                  result.verdict = VERDICT_KEY_DIFF;
                  stopped_in     = 1'b1;
               end
            end
         end
      end
      result.halted = stopped_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prompt_pos_ff <= '0;
         host_pos_ff   <= '0;
         key_pos_ff    <= '0;
         seen_ff       <= 1'b0;
         stopped_ff    <= 1'b0;
      end else if (advance) begin
         prompt_pos_ff <= prompt_pos_in;
         host_pos_ff   <= host_pos_in;
         key_pos_ff    <= key_pos_in;
         seen_ff       <= seen_in;
         stopped_ff    <= stopped_in;
      end
   end

endmodule

// File: hdl/terminal_prompt_detector_unit.sv
// Terminal prompt detector top level: input register, matcher core,
// result register and prompt configuration. Depends on tpd_pkg, tpd_csr, tpd_core.
//
// Use: each req beat carries one terminal byte and a chunk_end flag; each
// accepted beat yields exactly one rsp beat (send_password, verdict, halted).
// Three matchers (configurable password prompt, unknown-host notice,
// changed-key notice) advance per byte; verdicts are taken on chunk_end.
// Once a verdict is given the block reports halted on every later beat.
// csr beats write the prompt length (index 0) and prompt bytes (1..4);
// csr_ready is always high, and writes belong only to idle periods.
// Path: a req beat passes the input register, then the result register, before
// rsp_valid rises. Throughput: one beat per cycle while the output is not stalled,
// set by the single combinational matcher update between the two registers.
// Stall: a held rsp beat keeps its value; the input register still takes
// one more beat, then req_ready drops until rsp_ready returns.
// Reset: synchronous; clears matchers and flags, loads the default prompt
// "assword" of length 7, and empties both registers.
module terminal_prompt_detector_unit
   import tpd_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  tpd_req_type              req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output tpd_rsp_type              rsp_data,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_data
);

   logic               in_valid_ff;
   tpd_req_type        in_data_ff;
   logic               out_valid_ff;
   tpd_rsp_type        out_data_ff;
   logic               advance;
   tpd_rsp_type        core_result;
   tpd_prompt_cfg_type prompt_cfg;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   tpd_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .prompt_cfg (prompt_cfg)
   );

   tpd_core u_core (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .item       (in_data_ff),
      .prompt_cfg (prompt_cfg),
      .result     (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready) in_valid_ff <= req_valid;
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) in_data_ff <= req_data;
      if (advance) out_data_ff <= core_result;
   end

endmodule

// File: hdl/tpd_checker.sv
// Port-level checker for the terminal prompt detector, bound to the top
// level. Depends on tpd_pkg and terminal_prompt_detector_unit.
module tpd_checker
   import tpd_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input tpd_rsp_type rsp_data
);

   logic halted_ff;
   logic sent_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         halted_ff <= 1'b0;
         sent_ff   <= 1'b0;
      end else if (rsp_valid && rsp_ready) begin
         if (rsp_data.halted) halted_ff <= 1'b1;
         if (rsp_data.send_password) sent_ff <= 1'b1;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat changed while stalled");

   a_verdict_halts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.verdict != VERDICT_NONE |-> rsp_data.halted)
      else $error("verdict without halt");

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && halted_ff |-> rsp_data.halted && !rsp_data.send_password
                                 && rsp_data.verdict == VERDICT_NONE)
      else $error("beat after halt not idle");

   a_send_once: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && sent_ff |-> !rsp_data.send_password)
      else $error("password requested twice");

endmodule

bind terminal_prompt_detector_unit tpd_checker u_checker (.*);

// File: dv/tb.sv
// Testbench for terminal_prompt_detector_unit: drives terminal bytes and prompt
// register writes, predicts each rsp beat (pinned probe beats take a fixed
// expectation) and compares it field by field. Depends on tpd_pkg and the unit under test.
module tb
   import tpd_pkg::*;
();

   typedef struct packed {
      logic [5:0] prompt_pos;
      logic [4:0] host_pos;
      logic [5:0] key_pos;
      logic       seen;
      logic       halted;
   } watch_state_type;

   typedef struct packed {
      logic [7:0]  term_byte;
      logic        chunk_end;
      logic        pinned;
      tpd_rsp_type want;
   } probe_row_type;

   typedef enum int {
      END_WRONG_PW, END_HOST, END_KEY, END_BOTH, END_EMPTY_PROMPT
   } ending_kind_type;
   typedef enum int {FROM_PROMPT, FROM_HOST, FROM_KEY, FROM_NOISE} text_source_type;

   localparam tpd_rsp_type RSP_QUIET = '{1'b0, VERDICT_NONE, 1'b0};
   localparam int PROBE_ROWS = 22;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   tpd_req_type            req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   tpd_rsp_type            rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   string host_notice = "The authenticity of host ";
   string key_notice = "differs from the key for the IP address";

   logic [PROMPT_LEN_W-1:0] prompt_len_cfg = 6'd7;
   logic [3:0][63:0]        prompt_words = {64'h0, 64'h0, 64'h0, 64'h0064_726F_7773_7361};
   watch_state_type         watch = '0;
   tpd_rsp_type             expected_verdicts[$];
   tpd_rsp_type             head;
   ending_kind_type         ending;
   bit                      hold_prompt = 1'b0;
   bit                      calm = 1'b0;
   int                      beats_sent = 0;
   int                      failures = 0;

   probe_row_type probe_table [PROBE_ROWS] = '{
      '{8'h00, 1'b1, 1'b1, RSP_QUIET},
      '{8'hFF, 1'b1, 1'b1, RSP_QUIET},
      '{"a",   1'b0, 1'b0, RSP_QUIET},
      '{"a",   1'b0, 1'b0, RSP_QUIET},
      '{"s",   1'b0, 1'b0, RSP_QUIET},
      '{"s",   1'b0, 1'b0, RSP_QUIET},
      '{"w",   1'b0, 1'b0, RSP_QUIET},
      '{"o",   1'b1, 1'b1, RSP_QUIET},
      '{"x",   1'b1, 1'b1, RSP_QUIET},
      '{"T",   1'b0, 1'b0, RSP_QUIET},
      '{"T",   1'b0, 1'b0, RSP_QUIET},
      '{"h",   1'b0, 1'b0, RSP_QUIET},
      '{"e",   1'b1, 1'b1, RSP_QUIET},
      '{" ",   1'b0, 1'b0, RSP_QUIET},
      '{"d",   1'b0, 1'b0, RSP_QUIET},
      '{"i",   1'b0, 1'b0, RSP_QUIET},
      '{"f",   1'b0, 1'b0, RSP_QUIET},
      '{"f",   1'b1, 1'b1, RSP_QUIET},
      '{"e",   1'b0, 1'b0, RSP_QUIET},
      '{"r",   1'b0, 1'b0, RSP_QUIET},
      '{8'h80, 1'b1, 1'b1, RSP_QUIET},
      '{8'h7F, 1'b0, 1'b0, RSP_QUIET}
   };

   terminal_prompt_detector_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int prompt_span();
      int n;
      n = int'(prompt_len_cfg);
      return (n > PROMPT_MAX_BYTES) ? PROMPT_MAX_BYTES : n;
   endfunction

   function automatic logic [7:0] pattern_byte(int i);
      if (i >= 32) return 8'h00;
      return prompt_words[i / 8][8 * (i % 8) +: 8];
   endfunction

   function automatic int chase(int pos, int len, logic [7:0] here, logic [7:0] first,
                                logic [7:0] b);
      if (pos >= len) return pos;
      if (here == b) return pos + 1;
      return (first == b) ? 1 : 0;
   endfunction

   function automatic tpd_rsp_type advance_watch(inout watch_state_type s,
                                                 input tpd_req_type r);
      tpd_rsp_type o;
      int span;
      o = RSP_QUIET;
      span = prompt_span();
      if (s.halted) begin
         o.halted = 1'b1;
         return o;
      end
      s.prompt_pos = 6'(chase(int'(s.prompt_pos), span, pattern_byte(int'(s.prompt_pos)),
                              pattern_byte(0), r.term_byte));
      s.host_pos = 5'(chase(int'(s.host_pos), host_notice.len(), host_notice[s.host_pos],
                            host_notice[0], r.term_byte));
      s.key_pos = 6'(chase(int'(s.key_pos), key_notice.len(), key_notice[s.key_pos],
                           key_notice[0], r.term_byte));
      if (r.chunk_end) begin
         if (int'(s.prompt_pos) >= span) begin
            if (!s.seen) begin
               o.send_password = 1'b1;
               s.prompt_pos = '0;
               s.seen = 1'b1;
            end else begin
               o.verdict = VERDICT_WRONG_PW;
               s.halted = 1'b1;
            end
         end
         if (!s.halted) begin
            if (int'(s.host_pos) >= host_notice.len()) begin
               o.verdict = VERDICT_HOST_NEW;
               s.halted = 1'b1;
            end else if (int'(s.key_pos) >= key_notice.len()) begin
               o.verdict = VERDICT_KEY_DIFF;
               s.halted = 1'b1;
            end
         end
      end
      o.halted = s.halted;
      return o;
   endfunction

   function automatic bit spoils(logic [7:0] b);
      watch_state_type trial;
      tpd_rsp_type o;
      trial = watch;
      o = advance_watch(trial, '{term_byte: b, chunk_end: 1'b1});
      return o.halted || (hold_prompt && o.send_password);
   endfunction

   task automatic send_beat(input tpd_req_type d, input bit pinned, input tpd_rsp_type want);
      tpd_rsp_type predicted;
      while (!calm && $urandom_range(0, 99) < 33) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= d;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = advance_watch(watch, d);
      expected_verdicts.push_back(pinned ? want : predicted);
      beats_sent++;
   endtask

   task automatic send_guarded(input logic [7:0] b, input bit mark_end);
      int tries;
      tries = 0;
      while (spoils(b) && tries < 32) begin
         b = 8'($urandom_range(0, 255));
         tries++;
      end
      send_beat('{term_byte: b, chunk_end: mark_end}, 1'b0, RSP_QUIET);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_verdicts.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_PROMPT_LENGTH:   prompt_len_cfg = val[PROMPT_LEN_W-1:0];
         CSR_PROMPT_BYTES_0:  prompt_words[0] = val;
         CSR_PROMPT_BYTES_8:  prompt_words[1] = val;
         CSR_PROMPT_BYTES_16: prompt_words[2] = val;
         CSR_PROMPT_BYTES_24: prompt_words[3] = val;
         default: ;
      endcase
   endtask

   task automatic retune_prompt(input int want_len, input logic [3:0][63:0] words);
      int j;
      settle();
      // keep the prompt matcher short of complete under the new length
      if (((want_len > PROMPT_MAX_BYTES) ? PROMPT_MAX_BYTES : want_len) <= int'(watch.prompt_pos))
         want_len = int'(watch.prompt_pos) + 1;
      write_csr(CSR_PROMPT_BYTES_0, words[0]);
      write_csr(CSR_PROMPT_BYTES_8, words[1]);
      write_csr(CSR_PROMPT_BYTES_16, words[2]);
      write_csr(CSR_PROMPT_BYTES_24, words[3]);
      write_csr(CSR_PROMPT_LENGTH, CSR_DATA_W'(want_len));
      for (j = int'(CSR_PROMPT_BYTES_24) + 1; j < (1 << CSR_INDEX_W); j++)
         write_csr(CSR_INDEX_W'(j), {$urandom, $urandom});
      csr_valid <= 1'b0;
   endtask

   task automatic send_fragment();
      text_source_type src;
      int pick, n, i, broken;
      logic [7:0] b;
      bit mark_end;
      pick = $urandom_range(0, 9);
      src = (pick < 3) ? FROM_PROMPT : (pick < 5) ? FROM_HOST : (pick < 7) ? FROM_KEY : FROM_NOISE;
      case (src)
         FROM_PROMPT: n = $urandom_range(1, (prompt_span() < 1) ? 1 : prompt_span());
         FROM_HOST:   n = $urandom_range(1, host_notice.len());
         FROM_KEY:    n = $urandom_range(1, key_notice.len());
         default:     n = $urandom_range(1, 8);
      endcase
      broken = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n - 1) : -1;
      for (i = 0; i < n; i++) begin
         case (src)
            FROM_PROMPT: b = pattern_byte(i);
            FROM_HOST:   b = host_notice[i];
            FROM_KEY:    b = key_notice[i];
            default:     b = 8'($urandom_range(0, 255));
         endcase
         if (i == broken) b = 8'($urandom_range(0, 255));
         mark_end = (i == n - 1) ? ($urandom_range(0, 1) == 1) : ($urandom_range(0, 5) == 0);
         send_guarded(b, mark_end);
      end
      if ($urandom_range(0, 39) == 0) settle();
   endtask

   task automatic run_stream(input int beats);
      int stop_at;
      stop_at = beats_sent + beats;
      while (beats_sent < stop_at) send_fragment();
   endtask

   task automatic pour_prompt(input bit mark_end);
      int i, span;
      span = prompt_span();
      for (i = 0; i < span; i++)
         send_beat('{term_byte: pattern_byte(i), chunk_end: mark_end && (i == span - 1)},
                   1'b0, RSP_QUIET);
   endtask

   task automatic pour_text(input string s, input bit mark_end);
      int i;
      for (i = 0; i < s.len(); i++)
         send_beat('{term_byte: s[i], chunk_end: mark_end && (i == s.len() - 1)},
                   1'b0, RSP_QUIET);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_verdicts.size() == 0) begin
            $display("%0t: unexpected rsp beat %b", $time, rsp_data);
            failures++;
         end else begin
            head = expected_verdicts.pop_front();
            if (rsp_data.send_password !== head.send_password) begin
               $display("%0t: send_password expected %0d got %0d", $time,
                        head.send_password, rsp_data.send_password);
               failures++;
            end
            if (rsp_data.verdict !== head.verdict) begin
               $display("%0t: verdict expected %0d got %0d", $time, head.verdict,
                        rsp_data.verdict);
               failures++;
            end
            if (rsp_data.halted !== head.halted) begin
               $display("%0t: halted expected %0d got %0d", $time, head.halted,
                        rsp_data.halted);
               failures++;
            end
         end
      end
      rsp_ready <= calm || ($urandom_range(0, 99) >= 33);
   end

   initial begin
      #3000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      int i, k;
      logic [3:0][63:0] words;
      ending = ending_kind_type'($urandom_range(0, int'(END_EMPTY_PROMPT)));
      hold_prompt = (ending == END_BOTH);
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < PROBE_ROWS; i++)
         send_beat('{term_byte: probe_table[i].term_byte, chunk_end: probe_table[i].chunk_end},
                   probe_table[i].pinned, probe_table[i].want);

      words = {{$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
               {$urandom, $urandom}};
      retune_prompt(PROMPT_MAX_BYTES, words);
      run_stream(107);

      calm = 1'b1;
      words = {{$urandom, $urandom}, 64'h0, {64{1'b1}}, {$urandom, $urandom}};
      retune_prompt(63, words);
      run_stream(107);
      calm = 1'b0;

      words = {{$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
               {$urandom, $urandom}};
      retune_prompt(1, words);
      run_stream(107);

      words = {{$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
               {$urandom, $urandom}};
      retune_prompt($urandom_range(2, 12), words);
      run_stream(107);

      if (ending == END_EMPTY_PROMPT) begin
         settle();
         write_csr(CSR_PROMPT_LENGTH, '0);
         csr_valid <= 1'b0;
      end
      for (k = 0; k < 6 && !watch.halted; k++) begin
         case (ending)
            END_WRONG_PW: pour_prompt(1'b1);
            END_HOST:     pour_text(host_notice, 1'b1);
            END_KEY:      pour_text(key_notice, 1'b1);
            END_BOTH: begin
               pour_prompt(1'b0);
               pour_text(host_notice, 1'b1);
            end
            default:
               send_beat('{term_byte: 8'($urandom_range(0, 255)), chunk_end: 1'b1},
                         1'b0, RSP_QUIET);
         endcase
      end
      for (k = 0; k < 8; k++)
         send_beat('{term_byte: 8'($urandom_range(0, 255)), chunk_end: 1'($urandom_range(0, 1))},
                   1'b0, RSP_QUIET);

      settle();
      repeat (6) @(posedge clock);
      if (failures == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
